[rtl/core/icpm_pkg.sv]
// ----------------------------------------------------------------------------
// icpm_pkg
// Shared widths, constants and types of the crossing period meter.
// ----------------------------------------------------------------------------
package icpm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 20;
    localparam int FRAC_BITS   = 16;
    localparam int TIME_BITS   = INDEX_BITS + FRAC_BITS;
    localparam int OUT_BITS    = 36;
    localparam int THR_BITS    = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [THR_BITS-1:0] THRESHOLD_RESET = -16'sd100;

    // register word indexes
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    // one timed crossing handed from front to back
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] den;
        logic [INDEX_BITS-1:0]  idx;
        logic                   emit;
    } crossing_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
        logic pop;
    } queue_status_t;

endpackage

[rtl/core/interpolated_crossing_period_meter_unit.sv]
// ----------------------------------------------------------------------------
// interpolated_crossing_period_meter_unit
// Times falling threshold crossings with a linear fraction, emits periods.
// ----------------------------------------------------------------------------
// input channel: sample and record_start, taken on in_valid high, in_stall low
// output channel: period_q16 in samples with 16 fraction bits, one beat per
//   crossing from the second crossing of a record onward
// config: apb port, threshold at address 0, pready always high
// throughput: one sample per cycle; in_stall rises only while the crossing
//   queue (4 entries) is full
// each crossing holds the one-bit-per-cycle divider through its division and
//   final step, and no new crossing is taken before then; crossings arriving
//   faster than that fill the queue and then back-pressure the input
// an output beat waiting on out_stall holds the divider after its next
//   result; samples keep flowing until the queue fills
// reset: threshold returns to -100, all crossing state and the queue are
//   cleared, the first sample afterwards starts a record
// ----------------------------------------------------------------------------
module interpolated_crossing_period_meter_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [icpm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   record_start,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [icpm_pkg::OUT_BITS-1:0]          period_q16,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [icpm_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [icpm_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [icpm_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import icpm_pkg::*;

    logic signed [THR_BITS-1:0] threshold_reg;
    logic                       reg_hit;
    crossing_t                  push_data;
    crossing_t                  pop_data;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_push;
    logic                       q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_THRESHOLD);
    assign prdata  = reg_hit ? APB_DATA_BITS'(threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            threshold_reg <= pwdata[THR_BITS-1:0];
        end
    end

    icpm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .record_start (record_start),
        .threshold    (threshold_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_data    (push_data)
    );

    icpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    icpm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .pop_data   (pop_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .period_q16 (period_q16)
    );

    // queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
        else $error("crossing queue overflow");

    // queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n) q_empty |-> !q_pop)
        else $error("crossing queue underflow");

    // a period is always strictly positive
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> period_q16 != '0)
        else $error("zero period emitted");

endmodule

[rtl/core/icpm_front.sv]
// ----------------------------------------------------------------------------
// icpm_front
// Tracks previous sample and index, detects falling crossings and queues them.
// ----------------------------------------------------------------------------
module icpm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [icpm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                record_start,
    input  logic signed [icpm_pkg::THR_BITS-1:0]    threshold,
    input  logic                                q_full,
    output logic                                push,
    output icpm_pkg::crossing_t                 push_data
);
    import icpm_pkg::*;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
    localparam int DIFF_BITS = (SAMPLE_BITS > THR_BITS ? SAMPLE_BITS : THR_BITS) + 1;

    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                          have_prev_reg, have_prev_next;
    logic [INDEX_BITS-1:0]         idx_reg, idx_next;
    logic                          seen_reg, seen_next;
    logic [INDEX_BITS-1:0]         last_idx_reg, last_idx_next;

    logic                          accept;
    logic [INDEX_BITS-1:0]         idx_inc;
    logic signed [DIFF_BITS-1:0]   prev_x, cur_x, thr_x, num_x, den_x;
    logic                          crossing;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    assign idx_inc = (idx_reg != INDEX_MAX) ? idx_reg + 1'b1 : idx_reg;
    assign prev_x  = DIFF_BITS'(prev_reg);
    assign cur_x   = DIFF_BITS'(sample);
    assign thr_x   = DIFF_BITS'(threshold);
    assign num_x   = prev_x - thr_x;
    assign den_x   = prev_x - cur_x;

    assign crossing = (prev_x > thr_x) && (cur_x < thr_x)
                      && (!seen_reg || idx_inc > last_idx_reg);

    always_comb
    begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        last_idx_next  = last_idx_reg;
        push           = 1'b0;
        push_data.num  = num_x[SAMPLE_BITS-1:0];
        push_data.den  = den_x[SAMPLE_BITS-1:0];
        push_data.idx  = idx_inc;
        push_data.emit = seen_reg;
        if (accept)
        begin
            prev_next = sample;
            if (record_start || !have_prev_reg)
            begin
                have_prev_next = 1'b1;
                idx_next       = '0;
                seen_next      = 1'b0;
                last_idx_next  = '0;
            end
            else
            begin
                idx_next = idx_inc;
                if (crossing)
                begin
                    push          = 1'b1;
                    seen_next     = 1'b1;
                    last_idx_next = idx_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            idx_reg       <= '0;
            seen_reg      <= 1'b0;
            last_idx_reg  <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            idx_reg       <= idx_next;
            seen_reg      <= seen_next;
            last_idx_reg  <= last_idx_next;
        end
    end

endmodule

[rtl/core/icpm_queue.sv]
// ----------------------------------------------------------------------------
// icpm_queue
// Small first-in first-out queue of crossings between front and back.
// ----------------------------------------------------------------------------
module icpm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  icpm_pkg::crossing_t   push_data,
    input  logic                  pop,
    output icpm_pkg::crossing_t   pop_data,
    output logic                  full,
    output logic                  empty
);
    import icpm_pkg::*;

    crossing_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]    count_reg, count_next;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = QPTR_BITS'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
        end
        if (pop)
        begin
            rd_ptr_next = QPTR_BITS'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/icpm_back.sv]
// ----------------------------------------------------------------------------
// icpm_back
// Serial fraction divider, crossing time and period output register.
// ----------------------------------------------------------------------------
module icpm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  icpm_pkg::crossing_t          pop_data,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [icpm_pkg::OUT_BITS-1:0] period_q16
);
    import icpm_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS);
    localparam int WIDE_BITS = (TIME_BITS > OUT_BITS) ? TIME_BITS : OUT_BITS;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);
    localparam logic [WIDE_BITS-1:0] OUT_MAX = WIDE_BITS'({OUT_BITS{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } state_t;

    state_t                  state_reg;
    logic [SAMPLE_BITS-1:0]  rem_reg;
    logic [SAMPLE_BITS-1:0]  den_reg;
    logic [FRAC_BITS-1:0]    quo_reg;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic                    emit_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [TIME_BITS-1:0]    last_t_reg;
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     period_reg;

    logic [SAMPLE_BITS:0]    rem_shift;
    logic [SAMPLE_BITS:0]    rem_sub;
    logic                    take;
    logic [TIME_BITS-1:0]    t_now;
    logic [WIDE_BITS-1:0]    diff_wide;
    logic [OUT_BITS-1:0]     period_sat;
    logic                    out_free;
    logic                    fin_load;

    // one restoring step per cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign take      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    assign t_now      = {idx_reg, quo_reg};
    assign diff_wide  = WIDE_BITS'(t_now - last_t_reg);
    assign period_sat = (diff_wide > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0]
                                              : diff_wide[OUT_BITS-1:0];

    assign out_free   = !out_valid_reg || !out_stall;
    assign fin_load   = (state_reg == S_FIN) && emit_reg && out_free;
    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign out_valid  = out_valid_reg;
    assign period_q16 = period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_t_reg    <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            den_reg       <= '0;
            quo_reg       <= '0;
            idx_reg       <= '0;
            emit_reg      <= 1'b0;
            period_reg    <= '0;
        end
        else
        begin
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        rem_reg   <= pop_data.num;
                        den_reg   <= pop_data.den;
                        idx_reg   <= pop_data.idx;
                        emit_reg  <= pop_data.emit;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= take ? rem_sub[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
                    quo_reg <= {quo_reg[FRAC_BITS-2:0], take};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!emit_reg)
                    begin
                        last_t_reg <= t_now;
                        state_reg  <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        period_reg    <= period_sat;
                        last_t_reg    <= t_now;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sv/tb_interpolated_crossing_period_meter_unit.sv]
// ----------------------------------------------------------------------------
// tb_interpolated_crossing_period_meter_unit
// Self-checking bench for the crossing period meter. Samples are fed from a
// queue through a valid/stall driver with random gaps; every accepted sample
// runs through an in-bench model of the crossing timer, and each period beat
// on the output is compared with the oldest predicted period. The threshold
// is reprogrammed over apb between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interpolated_crossing_period_meter_unit;

    import icpm_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int QUEUE_HIGH    = 512;
    localparam int MAX_PRINTS    = 100;
    localparam logic [APB_ADDR_BITS-1:0] THR_ADDR =
        APB_ADDR_BITS'(4 * int'(REG_THRESHOLD));

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          start;
    } sample_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          record_start = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [OUT_BITS-1:0]           period_q16;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]      paddr = '0;
    logic [APB_DATA_BITS-1:0]      pwdata = '0;
    logic [APB_DATA_BITS-1:0]      prdata;
    logic                          pready;

    interpolated_crossing_period_meter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .record_start (record_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .period_q16   (period_q16),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    sample_beat_t pending_samples[$];
    logic [OUT_BITS-1:0] expected_periods[$];
    int error_count = 0;
    int items_queued = 0;
    int periods_checked = 0;

    // crossing timer state
    logic signed [THR_BITS-1:0]    m_thr = THRESHOLD_RESET;
    logic signed [SAMPLE_BITS-1:0] m_prev = '0;
    logic                          m_have_prev = 1'b0;
    logic [INDEX_BITS-1:0]         m_index = '0;
    logic [TIME_BITS-1:0]          m_last = '0;
    logic                          m_seen = 1'b0;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch: %s", what);
    endtask

    task automatic advance_meter(input logic signed [SAMPLE_BITS-1:0] cur, input logic start);
        longint num;
        longint den;
        longint frac;
        logic [TIME_BITS-1:0] t_now;
        if (start || !m_have_prev)
        begin
            m_index = '0;
            m_last = '0;
            m_seen = 1'b0;
            m_have_prev = 1'b1;
            m_prev = cur;
        end
        else
        begin
            if (m_index != '1)
                m_index++;
            if (m_prev > m_thr && cur < m_thr &&
                (!m_seen || m_index > m_last[TIME_BITS-1:FRAC_BITS]))
            begin
                num = longint'(m_prev) - longint'(m_thr);
                den = longint'(m_prev) - longint'(cur);
                frac = (num << FRAC_BITS) / den;
                t_now = {m_index, {FRAC_BITS{1'b0}}} + TIME_BITS'(frac);
                if (m_seen)
                    expected_periods.push_back(OUT_BITS'(t_now - m_last));
                m_last = t_now;
                m_seen = 1'b1;
            end
            m_prev = cur;
        end
    endtask

    // ---------------- sample driver ----------------
    int gap_left;
    int quiet_left;
    int tx_roll;
    sample_beat_t next_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            quiet_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_meter(sample, record_start);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_beat = pending_samples.pop_front();
                    sample <= next_beat.value;
                    record_start <= next_beat.start;
                    in_valid <= 1'b1;
                    if (quiet_left > 0)
                    begin
                        quiet_left--;
                        gap_left = 0;
                    end
                    else
                    begin
                        tx_roll = $urandom_range(0, 999);
                        if (tx_roll < 8)
                            quiet_left = $urandom_range(30, 150);
                        if (tx_roll < 550)
                            gap_left = 0;
                        else if (tx_roll < 850)
                            gap_left = $urandom_range(1, 3);
                        else if (tx_roll < 970)
                            gap_left = $urandom_range(4, 12);
                        else
                            gap_left = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- period receiver ----------------
    int hold_left;
    int rx_quiet;
    int rx_roll;
    int beats_taken;
    int long_holds;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            rx_quiet = 0;
            beats_taken = 0;
            long_holds = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                beats_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if ((long_holds == 0 && beats_taken >= 15) ||
                     (long_holds == 1 && beats_taken >= 200))
            begin
                // long hold-off so the crossing queue fills and stalls the input
                hold_left = 300;
                long_holds++;
            end
            else if (rx_quiet > 0)
            begin
                rx_quiet--;
            end
            else
            begin
                rx_roll = $urandom_range(0, 999);
                if (rx_roll < 10)
                    rx_quiet = $urandom_range(20, 120);
                if (rx_roll < 600)
                    hold_left = 0;
                else if (rx_roll < 900)
                    hold_left = $urandom_range(1, 3);
                else if (rx_roll < 985)
                    hold_left = $urandom_range(4, 15);
                else
                    hold_left = $urandom_range(20, 60);
            end
            out_stall <= (hold_left != 0);
        end
    end

    // ---------------- period checker ----------------
    logic [OUT_BITS-1:0] want_period;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_periods.size() == 0)
            begin
                report_mismatch($sformatf("period beat %h with none expected", period_q16));
            end
            else
            begin
                want_period = expected_periods.pop_front();
                if (period_q16 !== want_period)
                    report_mismatch($sformatf("period beat %0d: got %h expected %h",
                                              periods_checked, period_q16, want_period));
                periods_checked++;
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_interpolated_crossing_period_meter_unit: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v > 32767)
            return 16'sd32767;
        else if (v < -32768)
            return -16'sd32768;
        else
            return SAMPLE_BITS'(v);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic start);
        sample_beat_t b;
        while (pending_samples.size() >= QUEUE_HIGH)
            @(posedge clk);
        b.value = v;
        b.start = start;
        pending_samples.push_back(b);
        items_queued++;
    endtask

    task automatic check_threshold_readback(input logic signed [THR_BITS-1:0] want);
        logic [APB_DATA_BITS-1:0] got;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= THR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[THR_BITS-1:0] !== want)
            report_mismatch($sformatf("threshold readback %h expected %h",
                                      got[THR_BITS-1:0], want));
    endtask

    task automatic program_threshold(input logic signed [THR_BITS-1:0] thr);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THR_ADDR;
        // upper bits are don't-care for a 16-bit register
        pwdata <= {(APB_DATA_BITS - THR_BITS)'($urandom), thr};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_thr = thr;
        check_threshold_readback(thr);
    endtask

    task automatic drain_meter();
        while (pending_samples.size() != 0 || in_valid || expected_periods.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // falling sawtooth around the threshold: one falling crossing per period
    task automatic push_sawtooth(input logic signed [THR_BITS-1:0] thr, input int len,
                                 input int per, input int amp, input int noise,
                                 input int ph0);
        int ph;
        int v;
        ph = ph0;
        for (int i = 0; i < len; i++)
        begin
            v = int'(thr) + amp - (2 * amp * ph) / (per - 1);
            if (noise > 0)
                v = v + int'($urandom_range(0, 2 * noise)) - noise;
            push_sample(clamp_sample(v), 1'b0);
            ph = (ph + 1) % per;
        end
    endtask

    task automatic push_random_items(input logic signed [THR_BITS-1:0] thr, input int n);
        int first;
        int roll;
        int len;
        int per;
        int amp;
        int noise;
        first = items_queued;
        while (items_queued - first < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                per = $urandom_range(2, 30);
                amp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(10, 30000);
                noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, amp) : 0;
                // a few records lose their start flag
                push_sample(clamp_sample(int'(thr) + int'($urandom_range(0, 2 * amp)) - amp),
                            $urandom_range(0, 19) != 0);
                push_sawtooth(thr, $urandom_range(8, 90), per, amp, noise,
                              $urandom_range(0, per - 1));
            end
            else if (roll < 88)
            begin
                len = $urandom_range(5, 30);
                for (int i = 0; i < len; i++)
                    push_sample(SAMPLE_BITS'($urandom), $urandom_range(0, 15) == 0);
            end
            else
            begin
                // hover at the threshold, equal values included
                len = $urandom_range(5, 20);
                for (int i = 0; i < len; i++)
                    push_sample(clamp_sample(int'(thr) + int'($urandom_range(0, 6)) - 3), 1'b0);
            end
        end
    endtask

    logic signed [THR_BITS-1:0] phase_thr[7];
    int dir_value[25];
    bit dir_start[25];

    initial
    begin
        phase_thr = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd12345, -16'sd20000,
                      THR_BITS'($urandom), THR_BITS'($urandom)};
        // first sample after reset carries no start flag
        dir_value = '{500, 32767, -32768, -100, 200, -100, -300, 300, -32768, -99,
                      -101, 32767, -101, 1000, -1000, 1000, -1000, -32768, 32767,
                      -32768, 0, -1, -32768, 32767, -32767};
        dir_start = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                      0, 0, 0, 0, 1, 0, 0, 0, 0,
                      0, 1, 0, 1, 0, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_threshold_readback(THRESHOLD_RESET);
        for (int i = 0; i < 25; i++)
            push_sample(clamp_sample(dir_value[i]), dir_start[i]);
        push_random_items(THRESHOLD_RESET, 230);
        drain_meter();

        for (int p = 0; p < 7; p++)
        begin
            program_threshold(phase_thr[p]);
            push_random_items(phase_thr[p], 195);
            drain_meter();
        end

        if (error_count == 0)
            $display("tb_interpolated_crossing_period_meter_unit: PASS");
        else
            $display("tb_interpolated_crossing_period_meter_unit: FAIL");
        $finish;
    end

endmodule

[interpolated_crossing_period_meter_unit.f]
rtl/core/icpm_pkg.sv
rtl/core/icpm_front.sv
rtl/core/icpm_queue.sv
rtl/core/icpm_back.sv
rtl/core/interpolated_crossing_period_meter_unit.sv
tb/sv/tb_interpolated_crossing_period_meter_unit.sv
